[src/rdn_pkg.sv]
// ----------------------------------------------------------------------------
// rdn_pkg: shared types and constants for the RGB565 downscaler
// Register indexes, reset sizes, the payload struct and the fixed-point
// reciprocals used to widen 5- and 6-bit channels to 8 bits.
// ----------------------------------------------------------------------------
`default_nettype none

package rdn_pkg;

  // Largest frame dimension handled by default
  localparam int MAX_DIM_DEFAULT = 1024;

  // Configuration register width and index width
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = 11'd480;
  localparam logic [CFG_W-1:0] TARGET_WIDTH_RESET  = 11'd96;
  localparam logic [CFG_W-1:0] TARGET_HEIGHT_RESET = 11'd96;

  // Field widths
  localparam int PIXEL_W = 16;
  localparam int NORM_W  = 16;
  localparam int COORD_W = 10;

  // floor(v*255/31) = (v * 255 * 33826) >> 20, exact for 5-bit v
  // floor(v*255/63) = (v * 255 * 16645) >> 20, exact for 6-bit v
  localparam int                 PROD_W      = 28;
  localparam int                 RECIP_SHIFT = 20;
  localparam logic [PROD_W-1:0]  RED_BLUE_K  = 28'd8625630;
  localparam logic [PROD_W-1:0]  GREEN_K     = 28'd4244475;

  // Kept pixel, as it travels from classifier to converter
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel565;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               frame_last;
  } kept_t;

  // Queue depth between the two halves
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[src/rdn_in_if.sv]
// ----------------------------------------------------------------------------
// rdn_in_if: camera pixel channel
// Valid/ready channel carrying one RGB565 pixel and its frame-start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdn_in_if;
  logic                        valid;
  logic                        ready;
  logic [rdn_pkg::PIXEL_W-1:0] pixel565;
  logic                        frame_start;

  modport source (output valid, output pixel565, output frame_start, input ready);
  modport sink   (input valid, input pixel565, input frame_start, output ready);
endinterface

`default_nettype wire

[src/rdn_out_if.sv]
// ----------------------------------------------------------------------------
// rdn_out_if: normalized pixel channel
// Valid/ready channel carrying one downscaled, normalized pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdn_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdn_pkg::NORM_W-1:0]  red_norm;
  logic [rdn_pkg::NORM_W-1:0]  green_norm;
  logic [rdn_pkg::NORM_W-1:0]  blue_norm;
  logic [rdn_pkg::COORD_W-1:0] out_col;
  logic [rdn_pkg::COORD_W-1:0] out_row;
  logic                        frame_last;

  modport source (output valid, output red_norm, output green_norm, output blue_norm,
                  output out_col, output out_row, output frame_last, input ready);
  modport sink   (input valid, input red_norm, input green_norm, input blue_norm,
                  input out_col, input out_row, input frame_last, output ready);
endinterface

`default_nettype wire

[src/rdn_front.sv]
// ----------------------------------------------------------------------------
// rdn_front: raster tracker and keep classifier
// Holds the size registers, follows the source position and decides, with
// exact accumulator compares, which pixels survive nearest-neighbor
// downscaling. Kept pixels are pushed into the queue with their coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module rdn_front #(
  parameter int MAX_DIM = rdn_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic [rdn_pkg::CFG_IDX_W-1:0] write_index,
  input  wire logic [rdn_pkg::CFG_W-1:0]     write_data,
  rdn_in_if.sink                             pixels,
  output logic                               push_valid,
  output rdn_pkg::kept_t                     push_data,
  input  wire logic                          push_ready
);

  localparam int CW    = $clog2(MAX_DIM + 1);     // holds a size
  localparam int DW    = $clog2(MAX_DIM);         // holds a position
  localparam int ACC_W = 2 * CW;                  // holds size * size
  localparam int XW    = (CW > rdn_pkg::CFG_W) ? CW : rdn_pkg::CFG_W;

  // Size registers, raw as written
  logic [rdn_pkg::CFG_W-1:0] source_width, source_height;
  logic [rdn_pkg::CFG_W-1:0] target_width, target_height;

  // Raster state
  logic [DW-1:0]    in_col, in_row;
  logic [CW-1:0]    next_out_col, next_out_row;
  logic [ACC_W-1:0] col_target_acc, row_target_acc;
  logic             row_kept;

  logic [DW-1:0]    in_col_next, in_row_next;
  logic [CW-1:0]    next_out_col_next, next_out_row_next;
  logic [ACC_W-1:0] col_target_acc_next, row_target_acc_next;
  logic             row_kept_next;

  // Clamp a register value to the range one .. MAX_DIM
  function automatic logic [CW-1:0] clamp_dim(input logic [rdn_pkg::CFG_W-1:0] v);
    logic [XW-1:0] vx;
    vx = XW'(v);
    if (vx == '0) begin
      clamp_dim = CW'(1);
    end else if (vx > XW'(MAX_DIM)) begin
      clamp_dim = CW'(MAX_DIM);
    end else begin
      clamp_dim = CW'(vx);
    end
  endfunction

  logic [CW-1:0] sw, sh, tw_c, th_c, tw, th;

  always_comb begin
    sw   = clamp_dim(source_width);
    sh   = clamp_dim(source_height);
    tw_c = clamp_dim(target_width);
    th_c = clamp_dim(target_height);
    // no upscaling: saturate target to source
    tw   = (tw_c > sw) ? sw : tw_c;
    th   = (th_c > sh) ? sh : th_c;
  end

  // Effective state after an optional frame-start clear
  logic [DW-1:0]    ic_e, ir_e;
  logic [CW-1:0]    noc_e, nor_e;
  logic [ACC_W-1:0] cacc_e, racc_e;
  logic             rk_e;

  always_comb begin
    if (pixels.frame_start) begin
      ic_e   = '0;
      ir_e   = '0;
      noc_e  = '0;
      nor_e  = '0;
      cacc_e = '0;
      racc_e = '0;
      rk_e   = 1'b1;
    end else begin
      ic_e   = in_col;
      ir_e   = in_row;
      noc_e  = next_out_col;
      nor_e  = next_out_row;
      cacc_e = col_target_acc;
      racc_e = row_target_acc;
      rk_e   = row_kept;
    end
  end

  // Column keep test and line/frame advance
  logic [CW-1:0]    ic1, ir1, noc1, nor1;
  logic [ACC_W-1:0] col_limit, row_limit;
  logic             keep, line_end, frame_end, row_adv;

  always_comb begin
    ic1       = CW'(ic_e) + CW'(1);
    ir1       = CW'(ir_e) + CW'(1);
    noc1      = noc_e + CW'(1);
    nor1      = nor_e + CW'(1);
    col_limit = ACC_W'(ic1) * ACC_W'(tw);
    row_limit = (ACC_W'(ir_e) + ACC_W'(2)) * ACC_W'(th);
    keep      = rk_e && (noc_e < tw) && (cacc_e < col_limit);
    line_end  = (ic1 >= sw);
    frame_end = (ir1 >= sh);
    row_adv   = rk_e && (nor_e < th);

    in_col_next         = ic_e;
    in_row_next         = ir_e;
    next_out_col_next   = noc_e;
    next_out_row_next   = nor_e;
    col_target_acc_next = cacc_e;
    row_target_acc_next = racc_e;
    row_kept_next       = rk_e;

    if (keep) begin
      next_out_col_next   = noc1;
      col_target_acc_next = cacc_e + ACC_W'(sw);
    end

    if (line_end) begin
      in_col_next         = '0;
      next_out_col_next   = '0;
      col_target_acc_next = '0;
      if (row_adv) begin
        next_out_row_next   = nor1;
        row_target_acc_next = racc_e + ACC_W'(sh);
      end
      if (frame_end) begin
        in_row_next         = '0;
        next_out_row_next   = '0;
        row_target_acc_next = '0;
        row_kept_next       = 1'b1;
      end else begin
        in_row_next   = DW'(ir1);
        row_kept_next = (next_out_row_next < th) && (row_target_acc_next < row_limit);
      end
    end else begin
      in_col_next = DW'(ic1);
    end
  end

  // Accept whenever the queue has room
  logic accept;
  assign pixels.ready = push_ready;
  assign accept       = pixels.valid && push_ready;

  assign push_valid           = accept && keep;
  assign push_data.pixel565   = pixels.pixel565;
  assign push_data.out_col    = rdn_pkg::COORD_W'(noc_e);
  assign push_data.out_row    = rdn_pkg::COORD_W'(nor_e);
  assign push_data.frame_last = (noc1 == tw) && (nor1 == th);

  // Hold size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= rdn_pkg::SOURCE_WIDTH_RESET;
      source_height <= rdn_pkg::SOURCE_HEIGHT_RESET;
      target_width  <= rdn_pkg::TARGET_WIDTH_RESET;
      target_height <= rdn_pkg::TARGET_HEIGHT_RESET;
    end else if (write_enable) begin
      case (rdn_pkg::cfg_reg_t'(write_index))
        rdn_pkg::REG_SOURCE_WIDTH:  source_width  <= write_data;
        rdn_pkg::REG_SOURCE_HEIGHT: source_height <= write_data;
        rdn_pkg::REG_TARGET_WIDTH:  target_width  <= write_data;
        rdn_pkg::REG_TARGET_HEIGHT: target_height <= write_data;
        default: ;
      endcase
    end
  end

  // Advance raster state on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col         <= '0;
      in_row         <= '0;
      next_out_col   <= '0;
      next_out_row   <= '0;
      col_target_acc <= '0;
      row_target_acc <= '0;
      row_kept       <= 1'b1;
    end else if (accept) begin
      in_col         <= in_col_next;
      in_row         <= in_row_next;
      next_out_col   <= next_out_col_next;
      next_out_row   <= next_out_row_next;
      col_target_acc <= col_target_acc_next;
      row_target_acc <= row_target_acc_next;
      row_kept       <= row_kept_next;
    end
  end

endmodule

`default_nettype wire

[src/rdn_queue.sv]
// ----------------------------------------------------------------------------
// rdn_queue: short FIFO of kept pixels
// Decouples the classifier from the converter so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module rdn_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire rdn_pkg::kept_t  push_data,
  output logic                 push_ready,
  output logic                 pop_valid,
  output rdn_pkg::kept_t       pop_data,
  input  wire logic            pop_ready
);

  localparam int DEPTH = rdn_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rdn_pkg::kept_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/rdn_back.sv]
// ----------------------------------------------------------------------------
// rdn_back: color widening and output register
// Widens 5/6-bit channels to 8 bits with exact reciprocal multiplies,
// replicates each byte to 16 bits and holds the result for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module rdn_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  input  wire rdn_pkg::kept_t  pop_data,
  output logic                 pop_ready,
  rdn_out_if.source            results
);

  localparam int PW = rdn_pkg::PROD_W;
  localparam int SH = rdn_pkg::RECIP_SHIFT;

  logic [PW-1:0] red_prod, green_prod, blue_prod;
  logic [7:0]    red8, green8, blue8;
  logic          load;

  // Widen channels: floor(v*255/31) and floor(v*255/63)
  always_comb begin
    red_prod   = PW'(pop_data.pixel565[15:11]) * rdn_pkg::RED_BLUE_K;
    green_prod = PW'(pop_data.pixel565[10:5])  * rdn_pkg::GREEN_K;
    blue_prod  = PW'(pop_data.pixel565[4:0])   * rdn_pkg::RED_BLUE_K;
    red8       = red_prod[SH+7:SH];
    green8     = green_prod[SH+7:SH];
    blue8      = blue_prod[SH+7:SH];
  end

  // Load when the output register is empty or being emptied
  assign pop_ready = !results.valid || results.ready;
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (pop_ready) begin
      results.valid <= pop_valid;
    end
  end

  // Hold payload; v8 * 257 is the byte repeated
  always_ff @(posedge clk) begin
    if (load) begin
      results.red_norm   <= {red8, red8};
      results.green_norm <= {green8, green8};
      results.blue_norm  <= {blue8, blue8};
      results.out_col    <= pop_data.out_col;
      results.out_row    <= pop_data.out_row;
      results.frame_last <= pop_data.frame_last;
    end
  end

endmodule

`default_nettype wire

[src/rgb565_downscale_normalize.sv]
// ----------------------------------------------------------------------------
// rgb565_downscale_normalize: RGB565 stream to normalized, downscaled RGB
// Nearest-neighbor decimation of a raster pixel stream with 16-bit
// normalized channel output.
//
//   channel       dir  handshake      payload
//   pixels        in   valid/ready    pixel565[16], frame_start[1]
//   results       out  valid/ready    red/green/blue_norm[16], out_col[10],
//                                     out_row[10], frame_last[1]
//   write_*       in   enable only    write_index[2], write_data[11]
//
// One pixel is accepted every cycle while the queue has room; a kept pixel
// reaches results through the queue, then the output register. The rate is
// set by the classifier's position update, one multiply and compare per
// axis. Reset is synchronous and needs no clearing pass.
// A stall on results fills the two-entry queue, then drops pixels.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_downscale_normalize #(
  parameter int MAX_DIM = rdn_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic [rdn_pkg::CFG_IDX_W-1:0] write_index,
  input  wire logic [rdn_pkg::CFG_W-1:0]     write_data,
  rdn_in_if.sink                             pixels,
  rdn_out_if.source                          results
);

  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  rdn_pkg::kept_t push_data, pop_data;

  rdn_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixels       (pixels),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  rdn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  rdn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule

`default_nettype wire

[tb/sv/rdn_downscale_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdn_downscale_check: prediction and comparison for the RGB565 downscaler
// Tracks the size registers from the write port. For every accepted pixel
// request it decides whether the pixel is kept and queues its normalized
// color and output position. Every accepted result is compared field by
// field with the oldest queued pixel.
// ----------------------------------------------------------------------------

module rdn_downscale_check (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic [rdn_pkg::CFG_IDX_W-1:0] write_index,
  input  wire logic [rdn_pkg::CFG_W-1:0]     write_data,
  rdn_in_if                                  pixels,
  rdn_out_if                                 results,
  output int                                 mismatches,
  output int                                 pending
);

  // Full-scale codes of the 5- and 6-bit channels
  localparam int unsigned RB_TOP = 31;
  localparam int unsigned G_TOP  = 63;

  typedef struct packed {
    logic [rdn_pkg::NORM_W-1:0]  red;
    logic [rdn_pkg::NORM_W-1:0]  green;
    logic [rdn_pkg::NORM_W-1:0]  blue;
    logic [rdn_pkg::COORD_W-1:0] col;
    logic [rdn_pkg::COORD_W-1:0] row;
    logic                        last;
  } norm_pixel_t;

  // Size registers as written
  logic [rdn_pkg::CFG_W-1:0] src_w, src_h, dst_w, dst_h;

  // Raster position and decimation accumulators
  logic [9:0]  src_col, src_row;
  logic [10:0] out_col_next, out_row_next;
  logic [20:0] col_acc, row_acc;
  logic        row_on;

  norm_pixel_t kept_q[$];
  int          errors;

  function automatic int unsigned fit_dim(logic [rdn_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > rdn_pkg::MAX_DIM_DEFAULT) return rdn_pkg::MAX_DIM_DEFAULT;
    return 32'(v);
  endfunction

  // Widen to 8 bits with floor division, then scale so 255 maps to 65535
  function automatic logic [rdn_pkg::NORM_W-1:0] norm_channel(int unsigned v,
                                                              int unsigned top);
    return rdn_pkg::NORM_W'(((v * 255) / top) * 257);
  endfunction

  function void restart_frame();
    src_col      = '0;
    src_row      = '0;
    out_col_next = '0;
    out_row_next = '0;
    col_acc      = '0;
    row_acc      = '0;
    row_on       = 1'b1;
  endfunction

  task automatic predict_pixel(input logic [rdn_pkg::PIXEL_W-1:0] px, input logic fs);
    int unsigned sw, sh, tw, th;
    norm_pixel_t kept;
    sw = fit_dim(src_w);
    sh = fit_dim(src_h);
    tw = fit_dim(dst_w);
    th = fit_dim(dst_h);
    // No upscaling: clip the target to the source
    if (tw > sw) tw = sw;
    if (th > sh) th = sh;
    if (fs) restart_frame();

    // Keep the column when the next output column falls inside this pixel
    if (row_on && out_col_next < tw && col_acc < (src_col + 1) * tw) begin
      kept.red   = norm_channel(32'(px[15:11]), RB_TOP);
      kept.green = norm_channel(32'(px[10:5]), G_TOP);
      kept.blue  = norm_channel(32'(px[4:0]), RB_TOP);
      kept.col   = out_col_next[rdn_pkg::COORD_W-1:0];
      kept.row   = out_row_next[rdn_pkg::COORD_W-1:0];
      kept.last  = (out_col_next + 1 == tw) && (out_row_next + 1 == th);
      kept_q.push_back(kept);
      out_col_next++;
      col_acc = col_acc + 21'(sw);
    end

    // Advance the raster position; wrap lines and frames
    if (src_col + 1 >= sw) begin
      src_col      = '0;
      out_col_next = '0;
      col_acc      = '0;
      if (row_on && out_row_next < th) begin
        out_row_next++;
        row_acc = row_acc + 21'(sh);
      end
      if (src_row + 1 >= sh) begin
        restart_frame();
      end else begin
        src_row++;
        row_on = (out_row_next < th) && (row_acc < (src_row + 1) * th);
      end
    end else begin
      src_col++;
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  task automatic compare_result();
    norm_pixel_t want;
    if (kept_q.size() == 0) begin
      errors++;
      $display("%0t result: expected none, got col %0d row %0d",
               $time, results.out_col, results.out_row);
    end else begin
      want = kept_q.pop_front();
      check_field("red_norm", 32'(want.red), 32'(results.red_norm));
      check_field("green_norm", 32'(want.green), 32'(results.green_norm));
      check_field("blue_norm", 32'(want.blue), 32'(results.blue_norm));
      check_field("out_col", 32'(want.col), 32'(results.out_col));
      check_field("out_row", 32'(want.row), 32'(results.out_row));
      check_field("frame_last", 32'(want.last), 32'(results.frame_last));
    end
  endtask

  // Follow register writes, check results, then predict from new pixels
  always @(posedge clk) begin
    if (rst) begin
      src_w = rdn_pkg::SOURCE_WIDTH_RESET;
      src_h = rdn_pkg::SOURCE_HEIGHT_RESET;
      dst_w = rdn_pkg::TARGET_WIDTH_RESET;
      dst_h = rdn_pkg::TARGET_HEIGHT_RESET;
      restart_frame();
      kept_q.delete();
      errors = 0;
    end else begin
      if (write_enable) begin
        case (rdn_pkg::cfg_reg_t'(write_index))
          rdn_pkg::REG_SOURCE_WIDTH:  src_w = write_data;
          rdn_pkg::REG_SOURCE_HEIGHT: src_h = write_data;
          rdn_pkg::REG_TARGET_WIDTH:  dst_w = write_data;
          rdn_pkg::REG_TARGET_HEIGHT: dst_h = write_data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) compare_result();
      if (pixels.valid && pixels.ready) predict_pixel(pixels.pixel565, pixels.frame_start);
    end
    mismatches <= errors;
    pending    <= kept_q.size();
  end

endmodule

[tb/sv/rgb565_downscale_normalize_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_downscale_normalize_test: stimulus and verdict for the downscaler
// Sends directed pixels for the size corner cases, a long stall phase, a
// full oversize line, then random frames under random and small sizes with
// random idling on both channels. Checking lives in rdn_downscale_check.
// ----------------------------------------------------------------------------

module rgb565_downscale_normalize_test;

  localparam int RANDOM_ITEMS = 760;
  localparam int HOLD_CYCLES  = 200;

  logic                          clk;
  logic                          rst;
  logic                          write_enable;
  logic [rdn_pkg::CFG_IDX_W-1:0] write_index;
  logic [rdn_pkg::CFG_W-1:0]     write_data;
  int                            mismatches;
  int                            pending;

  // Idling control shared by the sender and the receiver
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;
  bit hold_asked = 1'b0;

  rdn_in_if  pixels ();
  rdn_out_if results ();

  rgb565_downscale_normalize dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixels       (pixels),
    .results      (results)
  );

  rdn_downscale_check pixel_check (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .pixels       (pixels),
    .results      (results),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one pixel request after a random gap and hold it until taken
  task automatic send_pixel(input logic [rdn_pkg::PIXEL_W-1:0] px, input logic fs);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      pixels.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels.valid       <= 1'b1;
    pixels.pixel565    <= px;
    pixels.frame_start <= fs;
    do @(posedge clk); while (!pixels.ready);
  endtask

  // Wait for every kept pixel, then let the pipeline settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input rdn_pkg::cfg_reg_t idx,
                         input logic [rdn_pkg::CFG_W-1:0] val);
    write_index <= idx;
    write_data  <= val;
    @(posedge clk);
  endtask

  task automatic setup_sizes(input logic [rdn_pkg::CFG_W-1:0] sw,
                             input logic [rdn_pkg::CFG_W-1:0] sh,
                             input logic [rdn_pkg::CFG_W-1:0] tw,
                             input logic [rdn_pkg::CFG_W-1:0] th);
    wait_idle();
    write_enable <= 1'b1;
    put_reg(rdn_pkg::REG_SOURCE_WIDTH, sw);
    put_reg(rdn_pkg::REG_SOURCE_HEIGHT, sh);
    put_reg(rdn_pkg::REG_TARGET_WIDTH, tw);
    put_reg(rdn_pkg::REG_TARGET_HEIGHT, th);
    write_enable <= 1'b0;
  endtask

  // Random pixels, framed or continuing the current frame, rare stray starts
  task automatic run_phase(input logic [rdn_pkg::CFG_W-1:0] sw,
                           input logic [rdn_pkg::CFG_W-1:0] sh,
                           input logic [rdn_pkg::CFG_W-1:0] tw,
                           input logic [rdn_pkg::CFG_W-1:0] th,
                           input int n, input bit framed);
    setup_sizes(sw, sh, tw, th);
    for (int i = 0; i < n; i++) begin
      send_pixel(rdn_pkg::PIXEL_W'($urandom_range(0, 16'hFFFF)),
                 (framed && i == 0) || ($urandom_range(0, 49) == 0));
    end
    pixels.valid <= 1'b0;
  endtask

  // Result receiver: random stall per request, long hold-off on demand
  initial begin
    int stall;
    results.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_asked) begin
        hold_asked = 1'b0;
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        results.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results.ready <= 1'b1;
      do @(posedge clk); while (!results.valid);
    end
  end

  // Stimulus
  initial begin
    int random_items;
    int n;
    bit framed;
    rst                <= 1'b1;
    write_enable       <= 1'b0;
    write_index        <= rdn_pkg::REG_SOURCE_WIDTH;
    write_data         <= '0;
    pixels.valid       <= 1'b0;
    pixels.pixel565    <= '0;
    pixels.frame_start <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: 640x480 down to 96x96
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    pixels.valid <= 1'b0;

    // Zero sizes read as one, oversize target clipped to the source:
    // every pixel is a whole frame of its own
    setup_sizes(11'd0, 11'd0, 11'd2047, 11'd0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hF800, 1'b0);
    send_pixel(16'h07E0, 1'b1);
    send_pixel(16'h001F, 1'b0);
    send_pixel(16'hAAAA, 1'b0);
    send_pixel(16'h5555, 1'b0);
    pixels.valid <= 1'b0;

    // One 5x3 frame down to 3x2, running into the wrap of the frame
    run_phase(11'd5, 11'd3, 11'd3, 11'd2, 15, 1'b1);

    // Hold results off while pixels keep coming, so the input stalls
    tx_quiet   = 1'b1;
    hold_asked = 1'b1;
    run_phase(11'd8, 11'd8, 11'd8, 11'd8, 150, 1'b1);
    tx_quiet   = 1'b0;

    // Oversize source: one full 1024-pixel line, every column kept
    run_phase(11'd2047, 11'd1, 11'd1024, 11'd2047, 1024, 1'b1);

    // Random sizes, mostly small, some phases continuing the frame
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      n        = $urandom_range(20, 120);
      framed   = ($urandom_range(0, 3) != 0);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        run_phase(rdn_pkg::CFG_W'($urandom_range(0, 2047)),
                  rdn_pkg::CFG_W'($urandom_range(0, 2047)),
                  rdn_pkg::CFG_W'($urandom_range(0, 2047)),
                  rdn_pkg::CFG_W'($urandom_range(0, 2047)), n, framed);
      end else begin
        run_phase(rdn_pkg::CFG_W'($urandom_range(1, 12)),
                  rdn_pkg::CFG_W'($urandom_range(1, 10)),
                  rdn_pkg::CFG_W'($urandom_range(0, 14)),
                  rdn_pkg::CFG_W'($urandom_range(0, 12)), n, framed);
      end
      random_items += n;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Drain, then give stray results a chance to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
